// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/bmpse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bmpse_pkg;

    localparam int POS_WIDTH = 32;
    localparam int PS_W      = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE  = 2'd2;

    localparam logic MODE_HIDE    = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_BMP    = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE  = 3'd2;
    localparam logic [2:0] ST_BAD_OFFSET = 3'd3;
    localparam logic [2:0] ST_NO_SIG     = 3'd4;

    localparam logic [31:0] STEG_MAGIC = 32'h5354_4547;
    localparam logic [7:0]  LSB_CLEAR  = 8'hFE;
    localparam logic [7:0]  SIG_B      = 8'h42;
    localparam logic [7:0]  SIG_M      = 8'h4D;
    localparam int          HDR_BITS   = 64;
    localparam int          HDR_BYTES  = 8;
    localparam int          OFF_MIN    = 14;

    typedef struct packed {
        logic [7:0] cover_byte;
        logic [7:0] payload_byte;
        logic       first_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] cover_out;
        logic       payload_valid;
        logic [7:0] payload_out;
        logic       payload_last;
        logic [2:0] status;
        logic       embed_done;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/bmpse_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bmpse_in_reg
    import bmpse_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    input  wire logic     i_take,
    output logic          o_stall,
    output logic          o_valid,
    output t_in_item      o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     w_accept;

    // The held item leaves whenever the engine can take it.
    assign o_stall  = r_valid && !i_take;
    assign w_accept = i_valid && !o_stall;
    assign n_valid  = w_accept ? 1'b1 : (i_take ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

// ===== rtl/bmpse_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bmpse_engine
    import bmpse_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_fire,
    input  wire t_in_item              i_item,
    output t_result                    o_res
);

    // Configuration registers.
    logic        r_mode;
    logic [31:0] r_payload_length;
    logic [31:0] r_image_size;

    // Per-file state.
    logic [POS_WIDTH-1:0] r_byte_pos,   n_byte_pos;
    logic [PS_W-1:0]      r_pixel_start, n_pixel_start;
    logic [2:0]           r_bit_index,  n_bit_index;
    logic [7:0]           r_bit_shift,  n_bit_shift;
    logic [63:0]          r_hdr_shift,  n_hdr_shift;
    logic [31:0]          r_bytes_done, n_bytes_done;
    logic [31:0]          r_found_len,  n_found_len;
    logic [2:0]           r_error,      n_error;

    logic                 w_clr;
    logic [POS_WIDTH-1:0] w_cur;
    logic                 w_not_max;
    logic                 w_lsb;
    logic [32:0]          w_room;
    logic [28:0]          w_cap;
    logic [32:0]          w_need;
    logic                 w_cap_bad;
    logic                 w_in_region;
    logic [PS_W-1:0]      w_k;
    logic                 w_k_hdr;
    logic                 w_k_last_hdr;
    logic [63:0]          w_hdr_in;
    t_result              w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= MODE_HIDE;
            r_payload_length <= '0;
            r_image_size     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:        r_mode           <= i_cfg_data[0];
                CFG_PAYLOAD_LEN: r_payload_length <= i_cfg_data[31:0];
                CFG_IMAGE_SIZE:  r_image_size     <= i_cfg_data[31:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        w_clr     = i_item.first_byte;
        w_cur     = w_clr ? '0 : r_byte_pos;
        w_not_max = (w_cur != '1);
        w_lsb     = i_item.cover_byte[0];

        n_pixel_start = w_clr ? '0 : r_pixel_start;
        n_bit_index   = w_clr ? '0 : r_bit_index;
        n_bit_shift   = w_clr ? '0 : r_bit_shift;
        n_hdr_shift   = w_clr ? '0 : r_hdr_shift;
        n_bytes_done  = w_clr ? '0 : r_bytes_done;
        n_found_len   = w_clr ? '0 : r_found_len;
        n_error       = w_clr ? '0 : r_error;

        w_res               = '0;
        w_res.cover_out     = i_item.cover_byte;

        // Signature check, hide mode only.
        if (r_mode == MODE_HIDE && n_error == ST_OK) begin
            if ((w_cur == POS_WIDTH'(0) && i_item.cover_byte != SIG_B) ||
                (w_cur == POS_WIDTH'(1) && i_item.cover_byte != SIG_M)) begin
                n_error = ST_NOT_BMP;
            end
        end

        // Little-endian pixel offset from file bytes 10 to 13.
        if (w_cur == POS_WIDTH'(10)) begin
            n_pixel_start[7:0] = n_pixel_start[7:0] | i_item.cover_byte;
        end
        if (w_cur == POS_WIDTH'(11)) begin
            n_pixel_start[15:8] = n_pixel_start[15:8] | i_item.cover_byte;
        end
        if (w_cur == POS_WIDTH'(12)) begin
            n_pixel_start[23:16] = n_pixel_start[23:16] | i_item.cover_byte;
        end
        if (w_cur == POS_WIDTH'(13)) begin
            n_pixel_start[31:24] = n_pixel_start[31:24] | i_item.cover_byte;
        end

        // Capacity in bytes is (image_size - offset) / 8, less the header.
        w_room    = {1'b0, r_image_size} - {1'b0, n_pixel_start};
        w_cap     = w_room[31:3];
        w_need    = {1'b0, r_payload_length} + 33'(HDR_BYTES);
        w_cap_bad = w_room[32] || (w_cap[28:3] == '0) || (w_need > 33'(w_cap));

        if (w_cur == POS_WIDTH'(13) && n_error == ST_OK) begin
            if (n_pixel_start < PS_W'(OFF_MIN)) begin
                n_error = ST_BAD_OFFSET;
            end else if (r_mode == MODE_HIDE) begin
                if (w_cap_bad) begin
                    n_error = ST_TOO_LARGE;
                end else begin
                    n_found_len = r_payload_length;
                    n_hdr_shift = {r_payload_length, STEG_MAGIC};
                end
            end
        end

        w_in_region  = (n_error == ST_OK) && (w_cur >= POS_WIDTH'(OFF_MIN)) &&
                       (PS_W'(w_cur) >= n_pixel_start);
        w_k          = PS_W'(w_cur) - n_pixel_start;
        w_k_hdr      = (w_k < PS_W'(HDR_BITS));
        w_k_last_hdr = (w_k == PS_W'(HDR_BITS - 1));
        w_hdr_in     = {w_lsb, n_hdr_shift[63:1]};

        if (w_in_region && w_not_max) begin
            if (w_k_hdr) begin
                if (r_mode == MODE_HIDE) begin
                    w_res.cover_out = (i_item.cover_byte & LSB_CLEAR) | {7'd0, n_hdr_shift[0]};
                    n_hdr_shift     = {1'b0, n_hdr_shift[63:1]};
                end else begin
                    n_hdr_shift = w_hdr_in;
                    if (w_k_last_hdr) begin
                        if (w_hdr_in[31:0] != STEG_MAGIC) begin
                            n_error = ST_NO_SIG;
                        end else begin
                            n_found_len = w_hdr_in[63:32];
                        end
                    end
                end
            end else if (n_bytes_done < n_found_len) begin
                if (r_mode == MODE_HIDE) begin
                    if (n_bit_index == 3'd0) begin
                        n_bit_shift = i_item.payload_byte;
                    end
                    w_res.cover_out = (i_item.cover_byte & LSB_CLEAR) |
                                      {7'd0, n_bit_shift[n_bit_index]};
                end else begin
                    if (n_bit_index == 3'd0) begin
                        n_bit_shift = '0;
                    end
                    n_bit_shift[n_bit_index] = n_bit_shift[n_bit_index] | w_lsb;
                    if (n_bit_index == 3'd7) begin
                        w_res.payload_valid = 1'b1;
                        w_res.payload_out   = n_bit_shift;
                        w_res.payload_last  = (n_bytes_done + 32'd1 == n_found_len);
                    end
                end
                if (n_bit_index == 3'd7) begin
                    n_bytes_done = n_bytes_done + 32'd1;
                end
                n_bit_index = n_bit_index + 3'd1;
            end
        end

        w_res.embed_done = (n_error == ST_OK) && w_in_region &&
                           (!w_k_hdr || (w_k_last_hdr && w_not_max)) &&
                           (n_bytes_done == n_found_len);
        w_res.status     = n_error;

        n_byte_pos = w_not_max ? w_cur + POS_WIDTH'(1) : w_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos    <= '0;
            r_pixel_start <= '0;
            r_bit_index   <= '0;
            r_bit_shift   <= '0;
            r_hdr_shift   <= '0;
            r_bytes_done  <= '0;
            r_found_len   <= '0;
            r_error       <= ST_OK;
        end else if (i_fire) begin
            r_byte_pos    <= n_byte_pos;
            r_pixel_start <= n_pixel_start;
            r_bit_index   <= n_bit_index;
            r_bit_shift   <= n_bit_shift;
            r_hdr_shift   <= n_hdr_shift;
            r_bytes_done  <= n_bytes_done;
            r_found_len   <= n_found_len;
            r_error       <= n_error;
        end
    end

    assign o_res = w_res;

endmodule
`default_nettype wire

// ===== rtl/bmpse_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bmpse_out_reg
    import bmpse_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    input  wire logic    i_stall,
    output logic         o_free,
    output logic         o_valid,
    output t_result      o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // Free when empty or when the held result is taken this cycle.
    assign o_free  = !r_valid || !i_stall;
    assign n_valid = i_load ? 1'b1 : (o_free ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
`default_nettype wire

// ===== rtl/bmp_lsb_stego_embed_extract.sv =====
`timescale 1ns / 1ps
`default_nettype none
// LSB steganography over a BMP byte stream, one file byte per transaction. The block
// takes one byte every clock cycle while o_in_stall is low and returns one result per
// byte: each accepted byte is held in the input register, then takes a single pass of
// per-byte logic (bit replace, counters, offset and capacity check) into the result
// register. Mark byte 0 of each file with first_byte. In hide mode (mode 0) the
// file must start with "BM"; the pixel offset in bytes 10 to 13 and the configured
// image size decide whether payload_length bytes plus the 8-byte header fit. From the
// offset on, each cover byte's LSB carries the header (magic word, then payload length,
// both sent bit 0 first) and then the payload bits, LSB first; payload_byte is sampled
// on the first byte of each group of eight. In extract mode (mode 1) the LSBs are
// gathered back, the magic word is checked and each recovered payload byte appears
// with payload_valid, the final one also with payload_last. status reports the first
// error of the file (1 not BMP, 2 too large, 3 offset below 14, 4 no magic); after an
// error bytes pass unchanged. Write configuration only while the block is idle.

module bmp_lsb_stego_embed_extract
    import bmpse_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input channel.
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_cover_byte,
    input  wire logic [7:0]            i_payload_byte,
    input  wire logic                  i_first_byte,
    // Result channel.
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [7:0]                 o_cover_out,
    output logic                       o_payload_valid,
    output logic [7:0]                 o_payload_out,
    output logic                       o_payload_last,
    output logic [2:0]                 o_status,
    output logic                       o_embed_done
);

    t_in_item w_in_item;
    t_in_item w_held_item;
    logic     w_held_valid;
    logic     w_out_free;
    logic     w_fire;
    t_result  w_res;
    t_result  w_out_res;

    assign w_in_item.cover_byte   = i_cover_byte;
    assign w_in_item.payload_byte = i_payload_byte;
    assign w_in_item.first_byte   = i_first_byte;

    // The input register takes a byte whenever it is empty or its held byte moves
    // on in the same cycle. Once both registers hold a transaction, a stall on the
    // result side stalls the input in that same cycle.
    bmpse_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (w_in_item),
        .i_take  (w_out_free),
        .o_stall (o_in_stall),
        .o_valid (w_held_valid),
        .o_item  (w_held_item)
    );

    // A held byte is processed, and the file state advances, exactly when the
    // result register can load its result.
    assign w_fire = w_held_valid && w_out_free;

    bmpse_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (w_fire),
        .i_item     (w_held_item),
        .o_res      (w_res)
    );

    bmpse_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire),
        .i_res   (w_res),
        .i_stall (i_out_stall),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .o_res   (w_out_res)
    );

    assign o_cover_out     = w_out_res.cover_out;
    assign o_payload_valid = w_out_res.payload_valid;
    assign o_payload_out   = w_out_res.payload_out;
    assign o_payload_last  = w_out_res.payload_last;
    assign o_status        = w_out_res.status;
    assign o_embed_done    = w_out_res.embed_done;

endmodule
`default_nettype wire

// ===== rtl/bmpse_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bmpse_checker
    import bmpse_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_cover_out,
    input wire logic       o_payload_valid,
    input wire logic [7:0] o_payload_out,
    input wire logic       o_payload_last,
    input wire logic [2:0] o_status,
    input wire logic       o_embed_done
);

    // Recovered payload only appears on a file that has no error.
    `ASSERT_IMPL(a_payload_ok, i_clk, i_rst_n, o_out_valid && o_payload_valid, o_status == ST_OK)

    // Without a recovered byte the payload fields stay zero.
    `ASSERT_IMPL(a_payload_idle, i_clk, i_rst_n, o_out_valid && !o_payload_valid, (o_payload_out == 8'd0) && !o_payload_last)

    // Completion is never reported on a file in error.
    `ASSERT_IMPL(a_done_ok, i_clk, i_rst_n, o_out_valid && o_embed_done, o_status == ST_OK)

    // A stalled result stays on the port unchanged.
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_cover_out) && $stable(o_status))

endmodule

bind bmp_lsb_stego_embed_extract bmpse_checker u_bmpse_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_cover_out     (o_cover_out),
    .o_payload_valid (o_payload_valid),
    .o_payload_out   (o_payload_out),
    .o_payload_last  (o_payload_last),
    .o_status        (o_status),
    .o_embed_done    (o_embed_done)
);
`default_nettype wire
